>>> design/sdeds_pkg.sv
package sdeds_pkg;

  // command codes on the input channel
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // kind codes on the result channel
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] SEG_BLANK  = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [3:0] digit_select;
    logic [7:0] segments;
    logic       two_results;
  } result_t;

  // active-low seven segment code, dot off
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hD8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

>>> design/serial_digit_entry_display_scanner.sv
// serial digit entry and four-digit display scanner. each item is either a
// received byte (command 0) or a scan tick (command 1). bytes are echoed;
// ascii digits fill an entry buffer of DIGIT_COUNT places, and a carriage
// return copies the entry right-justified onto the display, clears it and
// adds a newline after the echo. a tick steps the scan position and gives
// the one-hot digit select with its active-low segment code. an item is
// registered in the input register on entry and its result is then loaded
// into the output register; one item is taken per cycle while the result
// channel does not stall, except that a carriage return holds the output
// register for its echo and then its newline before the next result loads.
module serial_digit_entry_display_scanner #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic       command,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] tx_byte,
  output logic [3:0] digit_select,
  output logic [7:0] segments,
  output logic       last
);

  // input register
  logic               in_full;
  logic               in_cmd;
  logic [7:0]         in_byte;
  logic               step;
  logic               can_load;
  sdeds_pkg::result_t res;

  // item moves on once the output register can take its result
  assign step      = in_full && can_load;
  assign cmd_stall = in_full && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!cmd_stall) begin
      in_full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_cmd  <= command;
      in_byte <= rx_byte;
    end
  end

  // entry buffer, shown digits, scan position and result decode
  sdeds_core #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (in_cmd),
    .rx   (in_byte),
    .res  (res)
  );

  // output register, plays the newline after a carriage return echo
  sdeds_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .res          (res),
    .res_stall    (res_stall),
    .can_load     (can_load),
    .res_valid    (res_valid),
    .kind         (kind),
    .tx_byte      (tx_byte),
    .digit_select (digit_select),
    .segments     (segments),
    .last         (last)
  );

endmodule

>>> design/sdeds_core.sv
module sdeds_core #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                cmd,
  input  logic [7:0]          rx,
  output sdeds_pkg::result_t  res
);

  localparam int CW = $clog2(DIGIT_COUNT + 1);
  localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [3:0]    entry_digits [DIGIT_COUNT];
  logic [3:0]    shown_digits [DIGIT_COUNT];
  logic [3:0]    latched      [DIGIT_COUNT];
  logic [CW-1:0] entry_count;
  logic [PW-1:0] scan_position;
  logic [PW-1:0] scan_position_next;
  logic [3:0]    sel;
  logic          is_cr;
  logic          is_digit;
  logic          room;

  assign is_cr    = (cmd == sdeds_pkg::CMD_RX) && (rx == sdeds_pkg::CR_BYTE);
  assign room     = entry_count < CW'(DIGIT_COUNT);
  always_comb begin
    is_digit = (cmd == sdeds_pkg::CMD_RX) &&
               (rx inside {[sdeds_pkg::ASCII_ZERO:sdeds_pkg::ASCII_NINE]});
  end

  assign scan_position_next = (scan_position == PW'(DIGIT_COUNT - 1)) ? '0
                            : scan_position + PW'(1);

  // right-justified copy of the entry, newest digit at position 0
  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_latch
    logic [CW-1:0] src;
    assign src        = entry_count - CW'(i) - CW'(1);
    assign latched[i] = (CW'(i) < entry_count) ? entry_digits[src[PW-1:0]] : 4'd0;
  end

  // only the first four positions have a select line
  for (genvar k = 0; k < 4; k++) begin : g_sel
    assign sel[k] = (k < DIGIT_COUNT) ? (scan_position_next == PW'(k)) : 1'b0;
  end

  always_comb begin
    res = '0;
    if (cmd == sdeds_pkg::CMD_TICK) begin
      res.kind         = sdeds_pkg::KIND_SCAN;
      res.digit_select = sel;
      res.segments     = sdeds_pkg::seg_code(shown_digits[scan_position_next]);
    end else begin
      res.kind        = sdeds_pkg::KIND_TX;
      res.tx_byte     = rx;
      res.two_results = is_cr;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_digit && room) begin
      entry_digits[entry_count[PW-1:0]] <= rx[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      scan_position <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) shown_digits[i] <= 4'd0;
    end else if (step) begin
      if (cmd == sdeds_pkg::CMD_TICK) begin
        scan_position <= scan_position_next;
      end else if (is_cr) begin
        entry_count <= '0;
        for (int i = 0; i < DIGIT_COUNT; i++) shown_digits[i] <= latched[i];
      end else if (is_digit && room) begin
        entry_count <= entry_count + CW'(1);
      end
    end
  end

endmodule

>>> design/sdeds_out.sv
module sdeds_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sdeds_pkg::result_t res,
  input  logic               res_stall,
  output logic               can_load,
  output logic               res_valid,
  output logic               kind,
  output logic [7:0]         tx_byte,
  output logic [3:0]         digit_select,
  output logic [7:0]         segments,
  output logic               last
);

  logic pending_lf;

  assign can_load = !res_valid || (!res_stall && !pending_lf);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pending_lf <= 1'b0;
    end else if (load) begin
      res_valid  <= 1'b1;
      pending_lf <= res.two_results;
    end else if (res_valid && !res_stall) begin
      if (pending_lf) begin
        pending_lf <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= res.kind;
      tx_byte      <= res.tx_byte;
      digit_select <= res.digit_select;
      segments     <= res.segments;
      last         <= !res.two_results;
    end else if (res_valid && !res_stall && pending_lf) begin
      tx_byte <= sdeds_pkg::LF_BYTE;
      last    <= 1'b1;
    end
  end

endmodule

>>> design/sdeds_checker.sv
module sdeds_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic       kind,
  input logic [7:0] tx_byte,
  input logic [3:0] digit_select,
  input logic [7:0] segments,
  input logic       last
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // scan update: at most one digit select, dot off, no transmit byte
  a_scan_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == sdeds_pkg::KIND_SCAN |->
      $onehot0(digit_select) && segments[7] && tx_byte == 8'h00 && last)
    else $error("bad scan update fields");

  // transmit item carries no display drive
  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == sdeds_pkg::KIND_TX |->
      digit_select == 4'h0 && segments == 8'h00)
    else $error("bad transmit item fields");

  // a carriage return echo is followed at once by the closing newline
  a_newline: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && kind == sdeds_pkg::KIND_TX &&
    tx_byte == sdeds_pkg::CR_BYTE && !last |=>
      res_valid && kind == sdeds_pkg::KIND_TX &&
      tx_byte == sdeds_pkg::LF_BYTE && last)
    else $error("newline missing after carriage return");

endmodule

bind serial_digit_entry_display_scanner sdeds_checker u_sdeds_checker (.*);
